// File: rtl/core/irpde_pkg.sv
// ----------------------------------------------------------------------------
// irpde_pkg
// Shared types and constants of the infrared pulse-distance encoder.
// ----------------------------------------------------------------------------
package irpde_pkg;

   localparam int NUM_REGS      = 8;
   localparam int REG_W         = 16;
   localparam int BITS_PER_BYTE = 8;
   localparam int START_SEGS    = 4;
   localparam int POS_W         = 5;

   // segment positions within the full list of one byte
   localparam logic [POS_W-1:0] POS_START     = POS_W'(0);
   localparam logic [POS_W-1:0] POS_FIRST_BIT = POS_W'(START_SEGS);
   localparam logic [POS_W-1:0] POS_LAST_BIT  = POS_W'(START_SEGS + 2*BITS_PER_BYTE - 1);
   localparam logic [POS_W-1:0] POS_CLOSE     = POS_W'(START_SEGS + 2*BITS_PER_BYTE);

   typedef enum logic [2:0] {
      REG_FREQ         = 3'd0,
      REG_START_MARK   = 3'd1,
      REG_START_SPACE  = 3'd2,
      REG_START_MARK2  = 3'd3,
      REG_START_SPACE2 = 3'd4,
      REG_BIT_MARK     = 3'd5,
      REG_ONE_SPACE    = 3'd6,
      REG_ZERO_SPACE   = 3'd7
   } reg_idx_type;

   // one segment descriptor: which register gives the duration, carrier state and last flag
   typedef struct packed {
      logic        valid;
      reg_idx_type sel;
      logic        carrier_on;
      logic        last;
   } seg_type;

   function automatic logic [REG_W-1:0] cfg_reset(input reg_idx_type idx);
      logic [REG_W-1:0] val;
      case (idx)
         REG_FREQ:         val = REG_W'(38000);
         REG_START_MARK:   val = REG_W'(9000);
         REG_START_SPACE:  val = REG_W'(4500);
         REG_START_MARK2:  val = REG_W'(0);
         REG_START_SPACE2: val = REG_W'(0);
         REG_BIT_MARK:     val = REG_W'(560);
         REG_ONE_SPACE:    val = REG_W'(1690);
         REG_ZERO_SPACE:   val = REG_W'(560);
         default:          val = '0;
      endcase
      return val;
   endfunction

endpackage

// File: rtl/core/irpde_seq.sv
// ----------------------------------------------------------------------------
// irpde_seq
// Input holding stage, segment sequencer and segment descriptor stage.
// ----------------------------------------------------------------------------
module irpde_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,  // payload_byte
   input  logic                             req_tuser,  // frame_start
   input  logic                             req_tlast,  // frame_end
   input  logic                             freq_zero,
   input  logic                             seg_ready,
   output irpde_pkg::seg_type               seg
);

   // stage A: input word
   logic                           a_valid_ff, a_valid_in;
   logic [7:0]                     a_byte_ff;
   logic                           a_first_ff;
   logic                           a_last_ff;

   // stage B: byte being walked through
   logic                           b_valid_ff, b_valid_in;
   logic [7:0]                     b_byte_ff, b_byte_in;
   logic                           b_last_ff, b_last_in;
   logic [irpde_pkg::POS_W-1:0]    b_pos_ff, b_pos_in;

   // stage C: descriptor
   irpde_pkg::seg_type             c_ff, c_in;

   logic                           c_ready;
   logic                           emit;
   logic                           seg_last;
   logic                           b_load;
   logic [irpde_pkg::POS_W-1:0]    rel;
   logic                           cur_bit;
   irpde_pkg::reg_idx_type         sel;

   always_comb begin
      c_ready  = !c_ff.valid || seg_ready;
      emit     = b_valid_ff && c_ready;
      seg_last = (b_pos_ff == irpde_pkg::POS_CLOSE) ||
                 ((b_pos_ff == irpde_pkg::POS_LAST_BIT) && !b_last_ff);
      b_load   = a_valid_ff && (!b_valid_ff || (emit && seg_last));
      req_tready = !a_valid_ff || b_load;
      a_valid_in = (a_valid_ff && !b_load) || (req_tvalid && req_tready);
   end

   // byte bit under the current space segment
   always_comb begin
      rel     = b_pos_ff - irpde_pkg::POS_FIRST_BIT;
      cur_bit = b_byte_ff[rel[3:1]];
      if (b_pos_ff == irpde_pkg::POS_START) begin
         sel = irpde_pkg::REG_START_MARK;
      end else if (b_pos_ff == irpde_pkg::POS_START + 1'b1) begin
         sel = irpde_pkg::REG_START_SPACE;
      end else if (b_pos_ff == irpde_pkg::POS_START + 2'd2) begin
         sel = irpde_pkg::REG_START_MARK2;
      end else if (b_pos_ff == irpde_pkg::POS_START + 2'd3) begin
         sel = irpde_pkg::REG_START_SPACE2;
      end else if (!b_pos_ff[0]) begin
         sel = irpde_pkg::REG_BIT_MARK;   // bit marks and the closing mark
      end else if (cur_bit) begin
         sel = irpde_pkg::REG_ONE_SPACE;
      end else begin
         sel = irpde_pkg::REG_ZERO_SPACE;
      end
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      b_byte_in  = b_byte_ff;
      b_last_in  = b_last_ff;
      b_pos_in   = b_pos_ff;
      if (b_load) begin
         // a zero carrier frequency drops the word without output
         b_valid_in = !freq_zero;
         b_byte_in  = a_byte_ff;
         b_last_in  = a_last_ff;
         b_pos_in   = a_first_ff ? irpde_pkg::POS_START : irpde_pkg::POS_FIRST_BIT;
      end else if (emit) begin
         if (seg_last) begin
            b_valid_in = 1'b0;
         end else begin
            b_pos_in = b_pos_ff + 1'b1;
         end
      end
   end

   always_comb begin
      c_in = c_ff;
      if (c_ready) begin
         c_in.valid      = emit;
         c_in.sel        = sel;
         c_in.carrier_on = !b_pos_ff[0];
         c_in.last       = seg_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_ff.valid <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_ff.valid <= c_in.valid;
      end
      c_ff.sel        <= c_in.sel;
      c_ff.carrier_on <= c_in.carrier_on;
      c_ff.last       <= c_in.last;
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         a_byte_ff  <= req_tdata;
         a_first_ff <= req_tuser;
         a_last_ff  <= req_tlast;
      end
      b_byte_ff       <= b_byte_in;
      b_last_ff       <= b_last_in;
      b_pos_ff        <= b_pos_in;
   end

   assign seg = c_ff;

endmodule

// File: rtl/core/ir_pulse_distance_encoder_top.sv
// An accepted word passes the input stage, the byte stage, the descriptor stage
// and the output stage. One segment per cycle while rsp_tready does not stall;
// a byte gives 16 to 21 segments (16 bit segments, plus 4 start segments and
// 1 closing mark as its flags ask), set by the segment sequencer. With a zero
// carrier frequency a byte is dropped without output. Reset (synchronous,
// active high) empties all stages and loads the register defaults.
// ----------------------------------------------------------------------------
// ir_pulse_distance_encoder_top
// Infrared pulse-distance encoder: payload bytes in, mark/space timing out.
// ----------------------------------------------------------------------------
module ir_pulse_distance_encoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] payload_byte
   input  logic        req_tuser,   // frame_start
   input  logic        req_tlast,   // frame_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] duration_us
   output logic        rsp_tuser,   // carrier_on
   output logic        rsp_tlast    // last_segment
);

   logic [irpde_pkg::REG_W-1:0] cfg_ff [irpde_pkg::NUM_REGS];

   irpde_pkg::seg_type          seg;
   logic                        seg_ready;
   logic                        freq_zero;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [15:0]                 rsp_dur_ff;
   logic                        rsp_on_ff;
   logic                        rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < irpde_pkg::NUM_REGS; i++) begin
            cfg_ff[irpde_pkg::reg_idx_type'(i)] <=
               irpde_pkg::cfg_reset(irpde_pkg::reg_idx_type'(i));
         end
      end else if (csr_we) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   assign freq_zero = (cfg_ff[irpde_pkg::REG_FREQ] == '0);

   irpde_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .freq_zero  (freq_zero),
      .seg_ready  (seg_ready),
      .seg        (seg)
   );

   // output stage: duration lookup
   always_comb begin
      seg_ready    = !rsp_valid_ff || rsp_tready;
      rsp_valid_in = seg_ready ? seg.valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (seg_ready) begin
         rsp_dur_ff  <= cfg_ff[seg.sel];
         rsp_on_ff   <= seg.carrier_on;
         rsp_last_ff <= seg.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_dur_ff;
   assign rsp_tuser  = rsp_on_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the IR pulse-distance encoder. Payload bytes are
// streamed in under several register settings, and every timing segment is
// compared against a list predicted from the byte, its frame flags and the
// current registers.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_PCT      = 37;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 24;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_WORDS   = 14;

   typedef struct packed {
      logic        carrier_on;
      logic [15:0] duration_us;
      logic        last_segment;
   } segment_type;

   class segment_scoreboard;
      logic [15:0] regs [irpde_pkg::NUM_REGS];
      segment_type expected_segments [$];
      int          mismatches;
      int          segments_checked;
      int          words_noted;

      function new();
         regs[irpde_pkg::REG_FREQ]         = 16'd38000;
         regs[irpde_pkg::REG_START_MARK]   = 16'd9000;
         regs[irpde_pkg::REG_START_SPACE]  = 16'd4500;
         regs[irpde_pkg::REG_START_MARK2]  = 16'd0;
         regs[irpde_pkg::REG_START_SPACE2] = 16'd0;
         regs[irpde_pkg::REG_BIT_MARK]     = 16'd560;
         regs[irpde_pkg::REG_ONE_SPACE]    = 16'd1690;
         regs[irpde_pkg::REG_ZERO_SPACE]   = 16'd560;
         mismatches       = 0;
         segments_checked = 0;
         words_noted      = 0;
      endfunction

      function void set_reg(irpde_pkg::reg_idx_type idx, logic [15:0] val);
         regs[idx] = val;
      endfunction

      function int pending();
         return expected_segments.size();
      endfunction

      function void add_segment(logic carrier, logic [15:0] dur, logic seg_last);
         segment_type seg;
         seg.carrier_on   = carrier;
         seg.duration_us  = dur;
         seg.last_segment = seg_last;
         expected_segments.push_back(seg);
      endfunction

      // expand one accepted byte into its mark/space list
      function void note_word(logic [7:0] payload, logic frame_first,
                              logic frame_last);
         words_noted++;
         // carrier off: nothing at all
         if (regs[irpde_pkg::REG_FREQ] == 16'd0) return;
         if (frame_first) begin
            add_segment(1'b1, regs[irpde_pkg::REG_START_MARK], 1'b0);
            add_segment(1'b0, regs[irpde_pkg::REG_START_SPACE], 1'b0);
            add_segment(1'b1, regs[irpde_pkg::REG_START_MARK2], 1'b0);
            add_segment(1'b0, regs[irpde_pkg::REG_START_SPACE2], 1'b0);
         end
         for (int b = 0; b < irpde_pkg::BITS_PER_BYTE; b++) begin
            add_segment(1'b1, regs[irpde_pkg::REG_BIT_MARK], 1'b0);
            add_segment(1'b0,
                        payload[b] ? regs[irpde_pkg::REG_ONE_SPACE]
                                   : regs[irpde_pkg::REG_ZERO_SPACE],
                        !frame_last && b == irpde_pkg::BITS_PER_BYTE - 1);
         end
         if (frame_last) add_segment(1'b1, regs[irpde_pkg::REG_BIT_MARK], 1'b1);
      endfunction

      function void check_segment(logic carrier, logic [15:0] dur, logic seg_last);
         segment_type want;
         if (expected_segments.size() == 0) begin
            mismatches++;
            $display("%0t: segment with none expected: expected nothing,", $time);
            $display("   actual on=%0b dur=%0d last=%0b", carrier, dur, seg_last);
            return;
         end
         want = expected_segments.pop_front();
         segments_checked++;
         if (carrier !== want.carrier_on) begin
            mismatches++;
            $display("%0t: carrier_on expected %0b actual %0b",
                     $time, want.carrier_on, carrier);
         end
         if (dur !== want.duration_us) begin
            mismatches++;
            $display("%0t: duration_us expected %0d actual %0d",
                     $time, want.duration_us, dur);
         end
         if (seg_last !== want.last_segment) begin
            mismatches++;
            $display("%0t: last_segment expected %0b actual %0b",
                     $time, want.last_segment, seg_last);
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_index  = '0;
   logic [15:0] csr_wdata  = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] payload_byte
   logic        req_tuser  = 1'b0; // frame_start
   logic        req_tlast  = 1'b0; // frame_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [15:0] duration_us
   logic        rsp_tuser;         // carrier_on
   logic        rsp_tlast;         // last_segment

   segment_scoreboard sb = new();
   logic [15:0] next_regs [irpde_pkg::NUM_REGS];
   bit          no_gaps = 1'b0;
   int          settings_used = 1;
   int          quiet_cycles = 0;

   ir_pulse_distance_encoder_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_segment(rsp_tuser, rsp_tdata, rsp_tlast);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   // valid stays high across back-to-back words; this task only drops it during a gap
   task automatic send_word(input logic [7:0] payload, input logic frame_first,
                            input logic frame_last);
      while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= payload;
      req_tuser  <= frame_first;
      req_tlast  <= frame_last;
      do @(posedge clock); while (!req_tready);
      sb.note_word(payload, frame_first, frame_last);
   endtask

   task automatic wait_drain();
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // block must be idle before registers change; zero-carrier words leave no trace
   task automatic settle_and_write();
      irpde_pkg::reg_idx_type idx;
      req_tvalid <= 1'b0;
      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      for (int i = 0; i < irpde_pkg::NUM_REGS; i++) begin
         idx        = irpde_pkg::reg_idx_type'(i);
         csr_we    <= 1'b1;
         csr_index <= idx;
         csr_wdata <= next_regs[idx];
         @(posedge clock);
         sb.set_reg(idx, next_regs[idx]);
      end
      csr_we <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [15:0] pick_duration();
      case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2, 3:    return 16'($urandom_range(0, 2000));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   initial begin
      int unsigned            frame_len;
      int                     phase_words;
      bit                     paused;
      irpde_pkg::reg_idx_type idx;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values: frame pieces, repeated starts, lone end
      send_word(8'h00, 1'b1, 1'b0);
      send_word(8'hFF, 1'b0, 1'b0);
      send_word(8'hA5, 1'b0, 1'b1);
      send_word(8'h5A, 1'b1, 1'b1);
      send_word(8'h3C, 1'b0, 1'b0);
      send_word(8'h81, 1'b0, 1'b1);
      send_word(8'h01, 1'b1, 1'b0);
      send_word(8'h80, 1'b1, 1'b0);

      // everything full scale, no idling
      for (int i = 0; i < irpde_pkg::NUM_REGS; i++) begin
         idx = irpde_pkg::reg_idx_type'(i);
         next_regs[idx] = 16'hFFFF;
      end
      no_gaps = 1'b1;
      settle_and_write();
      send_word(8'hFF, 1'b1, 1'b1);
      send_word(8'h00, 1'b1, 1'b1);
      send_word(8'h69, 1'b0, 1'b0);

      // zero-length segments are still sent
      for (int i = 0; i < irpde_pkg::NUM_REGS; i++) begin
         idx = irpde_pkg::reg_idx_type'(i);
         next_regs[idx] = 16'h0000;
      end
      next_regs[irpde_pkg::REG_FREQ] = 16'd1;
      no_gaps = 1'b0;
      settle_and_write();
      send_word(8'hC3, 1'b1, 1'b1);
      send_word(8'h0F, 1'b1, 1'b0);
      send_word(8'hF0, 1'b0, 1'b1);

      // carrier off: no output whatever the flags
      for (int i = 0; i < irpde_pkg::NUM_REGS; i++) begin
         idx = irpde_pkg::reg_idx_type'(i);
         next_regs[idx] = pick_duration();
      end
      next_regs[irpde_pkg::REG_FREQ] = 16'd0;
      settle_and_write();
      send_word(8'hFF, 1'b1, 1'b1);
      send_word(8'h00, 1'b1, 1'b0);
      send_word(8'h55, 1'b0, 1'b1);
      send_word(8'hAA, 1'b0, 1'b0);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         for (int i = 0; i < irpde_pkg::NUM_REGS; i++) begin
            idx = irpde_pkg::reg_idx_type'(i);
            next_regs[idx] = pick_duration();
         end
         next_regs[irpde_pkg::REG_FREQ] =
            ($urandom_range(0, 9) == 0) ? 16'd0 : pick_duration();
         if (next_regs[irpde_pkg::REG_FREQ] == 16'd0 && p > 0)
            next_regs[irpde_pkg::REG_FREQ] = 16'd38000;
         no_gaps = (p == 2);
         settle_and_write();
         phase_words = 0;
         paused = 1'b0;
         while (phase_words < PHASE_WORDS) begin
            if ($urandom_range(0, 99) < 80) begin
               frame_len = $urandom_range(1, 5);
               for (int k = 0; k < frame_len; k++)
                  send_word(8'($urandom_range(0, 255)), k == 0, k == frame_len - 1);
               phase_words += frame_len;
            end else begin
               // stray word with arbitrary flags
               send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
               phase_words++;
            end
            if (!paused && phase_words >= PHASE_WORDS / 2) begin
               paused = 1'b1;
               req_tvalid <= 1'b0;
               wait_drain();
            end
         end
      end

      req_tvalid <= 1'b0;
      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d payload bytes and %0d segments over %0d register settings,",
               sb.words_noted, sb.segments_checked, settings_used);
      $display("including carrier off, zero and full-scale durations and one-byte frames.");
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/irpde_pkg.sv
rtl/core/irpde_seq.sv
rtl/core/ir_pulse_distance_encoder_top.sv
sim/tb.sv
